@@ src/page_bitmap_allocator_assert.svh @@
// assertion macros used by the page bitmap allocator controller
`ifndef PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// condition must hold in the same cycle as the trigger
`define PBA_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("pba assertion failed");
// condition must hold in the cycle after the trigger
`define PBA_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("pba assertion failed");
`else
`define PBA_ASSERT_SAME(lbl, trig, cond)
`define PBA_ASSERT_NEXT(lbl, trig, cond)
`endif
`endif

@@ src/pba_pkg.sv @@
// shared types and constants of the page bitmap allocator
`timescale 1ns / 1ps

package pba_pkg;

  // counter, page number and byte address widths
  localparam int CW = 22;
  localparam int NW = 26;
  localparam int LW = 40;

  // request kinds
  localparam logic [2:0] K_ALLOC   = 3'd0;
  localparam logic [2:0] K_FREE    = 3'd1;
  localparam logic [2:0] K_RESERVE = 3'd2;
  localparam logic [2:0] K_RELEASE = 3'd3;
  localparam logic [2:0] K_INIT    = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOMEM   = 2'd2;
  localparam logic [1:0] ST_OWNER   = 2'd3;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b0_0000_0001,
    S_IDLE  = 9'b0_0000_0010,
    S_SET1  = 9'b0_0000_0100,
    S_SET2  = 9'b0_0000_1000,
    S_CAND  = 9'b0_0001_0000,
    S_RD    = 9'b0_0010_0000,
    S_EX    = 9'b0_0100_0000,
    S_OUT   = 9'b0_1000_0000,
    S_FILL  = 9'b1_0000_0000
  } state_t;

  typedef enum logic [5:0] {
    PH_REL   = 6'b00_0001,
    PH_RES   = 6'b00_0010,
    PH_CHK   = 6'b00_0100,
    PH_FCLR  = 6'b00_1000,
    PH_SCAN  = 6'b01_0000,
    PH_CLAIM = 6'b10_0000
  } phase_t;

  typedef enum logic [4:0] {
    C_NOP, C_CLR_STEP, C_INIT, C_LOAD, C_SET1, C_SET2,
    C_CAND_NEXT, C_SCAN_START, C_EX_REL, C_EX_RES, C_EX_CHK,
    C_EX_FCLR, C_EX_SCAN, C_EX_CLAIM, C_FREE_RESTART, C_CLAIM_START,
    C_FIN_OK, C_FIN_ALLOC, C_FIN_FREE, C_FIN_BAD, C_FIN_NOMEM, C_FIN_OWNER
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       bad;
    logic       nomem;
    logic       loop_end;
    logic       cand_end;
    logic       cand_ok;
    logic       used;
    logic       owner_fail;
    logic       scan_last;
    logic       clr_last;
  } stat_t;

endpackage

@@ src/pba_dp.sv @@
// datapath: bitmap memory, request registers, page pointers and counters
`timescale 1ns / 1ps

module pba_dp #(
  parameter int PAGE_SHIFT = 12,
  parameter int MAX_PAGES  = 2097152
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [21:0]          cfg_wdata,
  input  logic [2:0]           s_tuser,
  input  logic [199:0]         s_tdata,
  input  pba_pkg::cmd_t        cmd,
  output pba_pkg::stat_t       stat,
  output logic [79:0]          m_tdata
);

  localparam int CW = pba_pkg::CW;
  localparam int NW = pba_pkg::NW;
  localparam int LW = pba_pkg::LW;
  localparam int MAP_WORDS = (MAX_PAGES + 31) / 32;
  localparam int WAW = $clog2(MAP_WORDS);
  localparam logic [LW-1:0] PS_B = LW'(1) << PAGE_SHIFT;
  localparam logic [CW-1:0] MAXP = CW'(MAX_PAGES);

  // control registers
  logic [CW-1:0]  managed, rc, ac;
  logic [WAW-1:0] clr_ptr;

  // request payload
  logic [2:0]  kind;
  logic [32:0] addr;
  logic [33:0] len, align, bound;
  logic [63:0] maxa;

  // derived request values
  logic          bad_a, bad_f, skip;
  logic [NW-1:0] need, amask, hi, lo, q, qend;
  logic [LW-1:0] bmask, endb, nbm1;
  logic [1:0]    res_st;
  logic [32:0]   res_addr;

  // bitmap words, used bits low and reserved bits high
  logic [63:0] mem [MAP_WORDS];
  logic [63:0] rdata;

  logic [CW-1:0]  npages;
  logic [LW-1:0]  limit, sum, align_eff, res_last_w, fb, lb;
  logic [NW-1:0]  need_c, amask_c, hi_c, rel_first, rel_last, res_last;
  logic [NW:0]    free_end;
  logic           bound_bad;
  logic [WAW-1:0] qw;
  logic [4:0]     bitsel;
  logic [31:0]    used_w, res_w, bm;
  logic           used_b, res_b;
  logic           we;
  logic [WAW-1:0] waddr;
  logic [63:0]    wdata;

  // request arithmetic
  always_comb begin
    npages     = (managed > MAXP) ? MAXP : managed;
    limit      = LW'(npages) << PAGE_SHIFT;
    sum        = LW'(addr) + LW'(len);
    align_eff  = (align == '0) ? PS_B : LW'(align);
    need_c     = NW'((LW'(len) + PS_B - LW'(1)) >> PAGE_SHIFT);
    amask_c    = NW'((align_eff >> PAGE_SHIFT) - LW'(1));
    bound_bad  = (bound != '0) && ((bound & (bound - 34'd1)) != '0);
    hi_c       = (maxa < 64'(limit)) ? NW'((maxa[LW-1:0] + LW'(1)) >> PAGE_SHIFT)
                                     : NW'(npages);
    rel_first  = NW'((LW'(addr) + PS_B - LW'(1)) >> PAGE_SHIFT);
    rel_last   = NW'(endb >> PAGE_SHIFT);
    res_last_w = (endb + PS_B - LW'(1)) >> PAGE_SHIFT;
    res_last   = (res_last_w > LW'(npages)) ? NW'(npages) : NW'(res_last_w);
    free_end   = (NW+1)'(lo) + (NW+1)'(need);
    fb         = LW'(lo) << PAGE_SHIFT;
    lb         = fb + nbm1;
  end

  // bit select of the current page
  assign qw     = q[WAW+4:5];
  assign bitsel = q[4:0];
  assign used_w = rdata[31:0];
  assign res_w  = rdata[63:32];
  assign bm     = 32'd1 << bitsel;
  assign used_b = used_w[bitsel];
  assign res_b  = res_w[bitsel];

  // status toward the controller
  always_comb begin
    stat.kind       = kind;
    stat.bad        = (kind == pba_pkg::K_ALLOC) ? bad_a :
                      (bad_f || ((NW+1)'(lo) >= (NW+1)'(npages)) ||
                       (free_end > (NW+1)'(npages)));
    stat.nomem      = need >= hi;
    stat.loop_end   = q >= qend;
    stat.cand_end   = free_end > (NW+1)'(hi);
    stat.cand_ok    = ((lo & amask) == '0) && (((fb ^ lb) & bmask) == '0);
    stat.used       = used_b;
    stat.owner_fail = !used_b || res_b;
    stat.scan_last  = (q + NW'(1)) == qend;
    stat.clr_last   = clr_ptr == WAW'(MAP_WORDS - 1);
  end

  // bitmap write port
  always_comb begin
    we    = 1'b0;
    waddr = qw;
    wdata = rdata;
    case (cmd)
      pba_pkg::C_CLR_STEP: begin
        we    = 1'b1;
        waddr = clr_ptr;
        wdata = '1;
      end
      pba_pkg::C_EX_REL: begin
        we    = used_b;
        wdata = {res_w & ~bm, used_w & ~bm};
      end
      pba_pkg::C_EX_RES: begin
        we    = !used_b;
        wdata = {res_w | bm, used_w | bm};
      end
      pba_pkg::C_EX_FCLR: begin
        we    = 1'b1;
        wdata = {res_w, used_w & ~bm};
      end
      pba_pkg::C_EX_CLAIM: begin
        we    = 1'b1;
        wdata = {res_w, used_w | bm};
      end
      default: ;
    endcase
  end

  // bitmap memory with registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[qw];
  end

  // counters, config and sweep pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      managed <= '0;
      rc      <= '0;
      ac      <= '0;
      clr_ptr <= '0;
    end else begin
      if (cfg_we) begin
        managed <= cfg_wdata;
      end
      case (cmd)
        pba_pkg::C_CLR_STEP: clr_ptr <= stat.clr_last ? '0 : clr_ptr + WAW'(1);
        pba_pkg::C_INIT: begin
          rc      <= npages;
          ac      <= '0;
          clr_ptr <= '0;
        end
        pba_pkg::C_EX_REL: if (used_b) rc <= rc - CW'(1);
        pba_pkg::C_EX_RES: if (!used_b) rc <= rc + CW'(1);
        pba_pkg::C_FIN_ALLOC: ac <= ac + CW'(need);
        pba_pkg::C_FIN_FREE: ac <= ac - CW'(need);
        default: ;
      endcase
    end
  end

  // request payload and page pointers
  always_ff @(posedge clk) begin
    case (cmd)
      pba_pkg::C_LOAD: begin
        kind  <= s_tuser;
        addr  <= s_tdata[32:0];
        len   <= s_tdata[66:33];
        align <= s_tdata[100:67];
        maxa  <= s_tdata[164:101];
        bound <= s_tdata[198:165];
      end
      pba_pkg::C_SET1: begin
        bad_a <= (len == '0) || (align_eff < PS_B) || bound_bad;
        bad_f <= (len == '0) || (addr[PAGE_SHIFT-1:0] != '0);
        skip  <= (len == '0) || (LW'(addr) >= limit);
        need  <= need_c;
        amask <= amask_c;
        hi    <= hi_c;
        lo    <= NW'(LW'(addr) >> PAGE_SHIFT);
        bmask <= (bound == '0) ? '0 : ~(LW'(bound) - LW'(1));
        endb  <= (sum > limit) ? limit : sum;
      end
      pba_pkg::C_SET2: begin
        nbm1 <= (LW'(need) << PAGE_SHIFT) - LW'(1);
        if (kind == pba_pkg::K_ALLOC) begin
          lo <= NW'(1);
        end else if (kind == pba_pkg::K_FREE) begin
          q    <= lo;
          qend <= NW'(free_end);
        end else if (kind == pba_pkg::K_RESERVE) begin
          q    <= lo;
          qend <= skip ? '0 : res_last;
        end else begin
          q    <= rel_first;
          qend <= skip ? '0 : rel_last;
        end
      end
      pba_pkg::C_CAND_NEXT: lo <= lo + NW'(1);
      pba_pkg::C_SCAN_START: begin
        q    <= lo;
        qend <= NW'(free_end);
      end
      pba_pkg::C_EX_REL, pba_pkg::C_EX_RES, pba_pkg::C_EX_CHK,
      pba_pkg::C_EX_FCLR, pba_pkg::C_EX_CLAIM: q <= q + NW'(1);
      pba_pkg::C_EX_SCAN: begin
        if (used_b) begin
          lo <= q + NW'(1);
        end else begin
          q <= q + NW'(1);
        end
      end
      pba_pkg::C_FREE_RESTART, pba_pkg::C_CLAIM_START: q <= lo;
      pba_pkg::C_INIT, pba_pkg::C_FIN_OK, pba_pkg::C_FIN_FREE: begin
        res_st   <= pba_pkg::ST_OK;
        res_addr <= '0;
      end
      pba_pkg::C_FIN_ALLOC: begin
        res_st   <= pba_pkg::ST_OK;
        res_addr <= 33'(LW'(lo) << PAGE_SHIFT);
      end
      pba_pkg::C_FIN_BAD: begin
        res_st   <= pba_pkg::ST_INVALID;
        res_addr <= '0;
      end
      pba_pkg::C_FIN_NOMEM: begin
        res_st   <= pba_pkg::ST_NOMEM;
        res_addr <= '0;
      end
      pba_pkg::C_FIN_OWNER: begin
        res_st   <= pba_pkg::ST_OWNER;
        res_addr <= '0;
      end
      default: ;
    endcase
  end

  // result beat
  assign m_tdata = {1'b0, ac, rc, res_addr, res_st};

endmodule

@@ src/pba_ctrl.sv @@
// controller: sequences setup, page loops, search and result for each request
`timescale 1ns / 1ps
`include "page_bitmap_allocator_assert.svh"

module pba_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  pba_pkg::stat_t   stat,
  output pba_pkg::cmd_t    cmd
);

  pba_pkg::state_t state, state_next;
  pba_pkg::phase_t phase, phase_next;
  logic            chk_fail;

  assign s_tready = (state == pba_pkg::S_IDLE);
  assign m_tvalid = (state == pba_pkg::S_OUT);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pba_pkg::S_CLEAR;
      phase <= pba_pkg::PH_REL;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // next state and datapath command
  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd        = pba_pkg::C_NOP;
    unique case (state)
      pba_pkg::S_CLEAR: begin
        cmd = pba_pkg::C_CLR_STEP;
        if (stat.clr_last) state_next = pba_pkg::S_IDLE;
      end
      pba_pkg::S_FILL: begin
        cmd = pba_pkg::C_CLR_STEP;
        if (stat.clr_last) state_next = pba_pkg::S_OUT;
      end
      pba_pkg::S_IDLE: begin
        if (s_tvalid) begin
          cmd        = pba_pkg::C_LOAD;
          state_next = pba_pkg::S_SET1;
        end
      end
      pba_pkg::S_SET1: begin
        if (stat.kind == pba_pkg::K_INIT) begin
          cmd        = pba_pkg::C_INIT;
          state_next = pba_pkg::S_FILL;
        end else if (stat.kind > pba_pkg::K_INIT) begin
          cmd        = pba_pkg::C_FIN_BAD;
          state_next = pba_pkg::S_OUT;
        end else begin
          cmd        = pba_pkg::C_SET1;
          state_next = pba_pkg::S_SET2;
        end
      end
      pba_pkg::S_SET2: begin
        if (stat.kind == pba_pkg::K_ALLOC) begin
          if (stat.bad) begin
            cmd        = pba_pkg::C_FIN_BAD;
            state_next = pba_pkg::S_OUT;
          end else if (stat.nomem) begin
            cmd        = pba_pkg::C_FIN_NOMEM;
            state_next = pba_pkg::S_OUT;
          end else begin
            cmd        = pba_pkg::C_SET2;
            state_next = pba_pkg::S_CAND;
          end
        end else if (stat.kind == pba_pkg::K_FREE) begin
          if (stat.bad) begin
            cmd        = pba_pkg::C_FIN_BAD;
            state_next = pba_pkg::S_OUT;
          end else begin
            cmd        = pba_pkg::C_SET2;
            phase_next = pba_pkg::PH_CHK;
            state_next = pba_pkg::S_RD;
          end
        end else begin
          cmd        = pba_pkg::C_SET2;
          phase_next = (stat.kind == pba_pkg::K_RESERVE) ? pba_pkg::PH_RES
                                                          : pba_pkg::PH_REL;
          state_next = pba_pkg::S_RD;
        end
      end
      pba_pkg::S_CAND: begin
        if (stat.cand_end) begin
          cmd        = pba_pkg::C_FIN_NOMEM;
          state_next = pba_pkg::S_OUT;
        end else if (!stat.cand_ok) begin
          cmd = pba_pkg::C_CAND_NEXT;
        end else begin
          cmd        = pba_pkg::C_SCAN_START;
          phase_next = pba_pkg::PH_SCAN;
          state_next = pba_pkg::S_RD;
        end
      end
      pba_pkg::S_RD: begin
        if (stat.loop_end) begin
          case (phase)
            pba_pkg::PH_CHK: begin
              cmd        = pba_pkg::C_FREE_RESTART;
              phase_next = pba_pkg::PH_FCLR;
            end
            pba_pkg::PH_FCLR: begin
              cmd        = pba_pkg::C_FIN_FREE;
              state_next = pba_pkg::S_OUT;
            end
            pba_pkg::PH_CLAIM: begin
              cmd        = pba_pkg::C_FIN_ALLOC;
              state_next = pba_pkg::S_OUT;
            end
            default: begin
              cmd        = pba_pkg::C_FIN_OK;
              state_next = pba_pkg::S_OUT;
            end
          endcase
        end else begin
          state_next = pba_pkg::S_EX;
        end
      end
      pba_pkg::S_EX: begin
        state_next = pba_pkg::S_RD;
        case (phase)
          pba_pkg::PH_REL:   cmd = pba_pkg::C_EX_REL;
          pba_pkg::PH_RES:   cmd = pba_pkg::C_EX_RES;
          pba_pkg::PH_FCLR:  cmd = pba_pkg::C_EX_FCLR;
          pba_pkg::PH_CLAIM: cmd = pba_pkg::C_EX_CLAIM;
          pba_pkg::PH_CHK: begin
            if (stat.owner_fail) begin
              cmd        = pba_pkg::C_FIN_OWNER;
              state_next = pba_pkg::S_OUT;
            end else begin
              cmd = pba_pkg::C_EX_CHK;
            end
          end
          default: begin
            if (stat.used) begin
              cmd        = pba_pkg::C_EX_SCAN;
              state_next = pba_pkg::S_CAND;
            end else if (stat.scan_last) begin
              cmd        = pba_pkg::C_CLAIM_START;
              phase_next = pba_pkg::PH_CLAIM;
            end else begin
              cmd = pba_pkg::C_EX_SCAN;
            end
          end
        endcase
      end
      pba_pkg::S_OUT: begin
        if (m_tready) state_next = pba_pkg::S_IDLE;
      end
      default: state_next = pba_pkg::S_CLEAR;
    endcase
  end

  // ownership check failing on the current page
  assign chk_fail = (state == pba_pkg::S_EX) && (phase == pba_pkg::PH_CHK) && stat.owner_fail;

  // checks
  `PBA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `PBA_ASSERT_NEXT(a_owner_fail_ends, chk_fail, m_tvalid)
  `PBA_ASSERT_NEXT(a_read_then_apply, state == pba_pkg::S_RD && !stat.loop_end, state == pba_pkg::S_EX)
  `PBA_ASSERT_SAME(a_no_beat_in_sweep, state == pba_pkg::S_CLEAR || state == pba_pkg::S_FILL, !m_tvalid && !s_tready)

endmodule

@@ src/page_bitmap_allocator.sv @@
// Page bitmap allocator, top level. One request beat in, one result beat out.
// After reset, and again for every initialize request, the block sweeps its
// bitmap memory filling it with ones, one 32-page word per cycle; no request
// is taken during the reset sweep, configuration writes are. Reserve, release
// and free run the setup states, then handle each page in the range with a
// read of the bitmap word and then a write back; a free checks every page,
// then clears it. An alloc rejects candidate starts one at a time, scans the
// pages of an accepted candidate, then claims its pages. Each page is read in
// one state and written in the next, as the bitmap memory read is registered.
// The user must write managed_pages over cfg_we/cfg_wdata only while idle;
// the block itself does not enforce this.
`timescale 1ns / 1ps

module page_bitmap_allocator #(
  parameter int PAGE_SHIFT = 12,
  parameter int MAX_PAGES  = 2097152
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [21:0]  cfg_wdata,   // managed_pages
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [2:0]   s_tuser,     // kind
  input  logic [199:0] s_tdata,     // address, length, alignment, max_address, boundary
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [79:0]  m_tdata      // status, block_address, reserved_total, allocated_total
);

  pba_pkg::cmd_t  cmd;
  pba_pkg::stat_t stat;

  // sequencer
  pba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // bitmap and arithmetic
  pba_dp #(
    .PAGE_SHIFT (PAGE_SHIFT),
    .MAX_PAGES  (MAX_PAGES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tdata   (m_tdata)
  );

endmodule
